@@ rtl/core/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants for the PWM pulse-width smoother
// Fixed widths, averaging constants and the state write controls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pps_pkg;

  localparam int TS_W    = 32;
  localparam int WIDTH_W = 16;
  localparam int SUM_W   = 20;
  localparam int PROD_W  = 40;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX = 16'hFFFF;

  // Division by ten as a multiplication by ceil(2^23 / 10) and a shift.
  // It is exact for every sum below 2^20.
  localparam logic [SUM_W-1:0] RECIP_MULT  = 20'd838861;
  localparam int               RECIP_SHIFT = 23;

  typedef logic [TS_W-1:0]    ts_t;
  typedef logic [WIDTH_W-1:0] width_t;

  typedef struct packed {
    logic rise_we;
    logic avg_we;
  } pps_wr_t;

endpackage

@@ rtl/core/pps_width_calc.sv @@
// ----------------------------------------------------------------------------
// pps_width_calc: high time and smoothed width
// Measures the high time, saturates it and folds it into the running average.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pps_width_calc
  import pps_pkg::*;
(
  input  ts_t    fall_time,
  input  ts_t    rise_time,
  input  width_t old_avg,
  output width_t new_avg
);

  ts_t                 diff;
  width_t              high;
  logic [SUM_W-1:0]    sum;
  logic [PROD_W-1:0]   prod;

  assign diff = fall_time - rise_time;
  assign high = (|diff[TS_W-1:WIDTH_W]) ? WIDTH_MAX : diff[WIDTH_W-1:0];

  // high + 9 * old, built as old * 8 + old + high.
  assign sum = {4'b0, high} + {1'b0, old_avg, 3'b0} + {4'b0, old_avg};

  assign prod    = {{(PROD_W-SUM_W){1'b0}}, sum} * {{(PROD_W-SUM_W){1'b0}}, RECIP_MULT};
  assign new_avg = prod[RECIP_SHIFT+WIDTH_W-1:RECIP_SHIFT];

endmodule

@@ rtl/core/pps_state.sv @@
// ----------------------------------------------------------------------------
// pps_state: per-channel rise time and average registers
// Holds the last rise time and the smoothed width of each channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pps_state
  import pps_pkg::*;
#(
  parameter int NUM_CHANNELS = 2,
  parameter int CHANNEL_W    = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CHANNEL_W-1:0] sel,
  input  pps_wr_t              wr,
  input  ts_t                  rise_data,
  input  width_t               avg_data,
  output ts_t                  rise_time,
  output width_t               width_average
);

  ts_t    rise_mem [NUM_CHANNELS];
  width_t avg_mem  [NUM_CHANNELS];
  logic   sel_ok;

  assign sel_ok = {1'b0, sel} < (CHANNEL_W+1)'(NUM_CHANNELS);

  assign rise_time     = sel_ok ? rise_mem[sel] : '0;
  assign width_average = sel_ok ? avg_mem[sel]  : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rise_mem[i] <= '0;
        avg_mem[i]  <= '0;
      end
    end else if (sel_ok) begin
      if (wr.rise_we) begin
        rise_mem[sel] <= rise_data;
      end
      if (wr.avg_we) begin
        avg_mem[sel] <= avg_data;
      end
    end
  end

endmodule

@@ rtl/core/pwm_pulse_width_smoother.sv @@
// ----------------------------------------------------------------------------
// pwm_pulse_width_smoother: two-channel PWM pulse-width decoder and smoother
// A falling-edge word passes the hold register, then the result register.
// Throughput: one edge word per cycle unless out_stall holds the result.
// Reset clears both valid flags and every rise time and average to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwm_pulse_width_smoother
  import pps_pkg::*;
#(
  parameter int NUM_CHANNELS = 2,
  localparam int CHANNEL_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CHANNEL_W-1:0] channel,
  input  logic                 level,
  input  ts_t                  timestamp_us,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CHANNEL_W-1:0] out_channel,
  output width_t               smoothed_width
);

  logic                 hold_valid;
  logic [CHANNEL_W-1:0] hold_channel;
  logic                 hold_level;
  ts_t                  hold_timestamp;

  logic    advance;
  logic    fire;
  logic    in_range;
  pps_wr_t wr;
  ts_t     rise_time;
  width_t  old_avg;
  width_t  new_avg;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = hold_valid && !advance;
  assign fire     = hold_valid && advance;
  assign in_range = {1'b0, hold_channel} < (CHANNEL_W+1)'(NUM_CHANNELS);

  assign wr.rise_we = fire && hold_level;
  assign wr.avg_we  = fire && !hold_level;

  pps_state #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .CHANNEL_W    (CHANNEL_W)
  ) u_state (
    .clk           (clk),
    .rst           (rst),
    .sel           (hold_channel),
    .wr            (wr),
    .rise_data     (hold_timestamp),
    .avg_data      (new_avg),
    .rise_time     (rise_time),
    .width_average (old_avg)
  );

  pps_width_calc u_calc (
    .fall_time (hold_timestamp),
    .rise_time (rise_time),
    .old_avg   (old_avg),
    .new_avg   (new_avg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_channel   <= channel;
      hold_level     <= level;
      hold_timestamp <= timestamp_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && !hold_level && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !hold_level && in_range) begin
      out_channel    <= hold_channel;
      smoothed_width <= new_avg;
    end
  end

endmodule
